/* hw/rtl/dq_pkg.sv */
// Shared types and codes for the bounded deque unit.
// Holds transaction structs, action and status codes, and the controller command struct.
// No dependencies.
package dq_pkg;

  localparam int ELEM_W = 32;
  localparam int POS_W  = 8;
  localparam int OCC_W  = 9;
  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;

  // Action codes (code 7 is unused and ignored)
  localparam logic [ACT_W-1:0] ACT_INS_HEAD = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_TAIL = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REM_HEAD = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REM_TAIL = 3'd3;
  localparam logic [ACT_W-1:0] ACT_RD_HEAD  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_RD_TAIL  = 3'd5;
  localparam logic [ACT_W-1:0] ACT_RD_AT    = 3'd6;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ELEM_W-1:0] element_in;
    logic [POS_W-1:0]  position;
  } dq_in_t;

  typedef struct packed {
    logic [ELEM_W-1:0] element_out;
    logic [OCC_W-1:0]  occupancy;
    logic [STAT_W-1:0] status;
  } dq_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;  // capture the incoming transaction
    logic exec;  // run the action: memory access and pointer update
  } dq_cmd_t;

endpackage

/* hw/rtl/dq_ram.sv */
// Generic single-port RAM with registered read data.
// No dependencies.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/dq_ctrl.sv */
// Controller for the bounded deque unit: idle / execute / done sequencer.
// Depends on dq_pkg.
module dq_ctrl
  import dq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  output logic    out_valid,
  output dq_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign busy   = (state_r == S_EXEC);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: state_nxt = accept ? S_EXEC : S_IDLE;
      S_EXEC: state_nxt = S_DONE;
      S_DONE: state_nxt = accept ? S_EXEC : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign out_valid = (state_r == S_DONE);
  assign cmd.load  = accept;
  assign cmd.exec  = (state_r == S_EXEC);

endmodule

/* hw/rtl/dq_dpath.sv */
// Datapath for the bounded deque unit: head pointer, count, ring address math, storage.
// Depends on dq_pkg and dq_ram.
module dq_dpath
  import dq_pkg::*;
#(
  parameter int CAPACITY     = 256,
  parameter int ELEMENT_BITS = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  dq_cmd_t cmd,
  input  dq_in_t  in_data,
  output dq_out_t out_data
);

  localparam int PW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int SW   = PW + 1;
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;
  localparam int KEEP = (ELEMENT_BITS < ELEM_W) ? ELEMENT_BITS : ELEM_W;
  localparam logic [SW-1:0] CAP_S = SW'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Captured transaction
  logic [ACT_W-1:0]  act_r;
  logic [ELEM_W-1:0] elem_r;
  logic [POS_W-1:0]  pos_r;

  // Ring state
  logic [PW-1:0]     head_r, head_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              rok_r, rok_nxt;

  logic                    ram_we, ram_re;
  logic [PW-1:0]           ram_addr;
  logic [ELEMENT_BITS-1:0] ram_wdata, ram_rdata;

  logic          full, empty;
  logic [PW-1:0] head_dec, head_inc, tail_slot, last_slot, at_slot;

  function automatic logic [PW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] t;
    t = (s >= CAP_S) ? (s - CAP_S) : s;
    return t[PW-1:0];
  endfunction

  assign full      = (count_r == CAP_C);
  assign empty     = (count_r == '0);
  assign head_dec  = (head_r == '0) ? PW'(CAPACITY - 1) : (head_r - PW'(1));
  assign head_inc  = wrap(SW'(head_r) + SW'(1));
  assign tail_slot = wrap(SW'(head_r) + SW'(count_r));
  assign last_slot = wrap(SW'(head_r) + SW'(count_r) - SW'(1));
  assign at_slot   = wrap(SW'(head_r) + SW'(pos_r));

  always_comb begin
    ram_wdata = '0;
    ram_wdata[KEEP-1:0] = elem_r[KEEP-1:0];
  end

  always_comb begin
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = head_r;
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = ST_OK;
    rok_nxt    = 1'b0;
    unique case (act_r)
      ACT_INS_HEAD: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_addr  = head_dec;
          head_nxt  = head_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_INS_TAIL: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_addr  = tail_slot;
          count_nxt = count_r + CW'(1);
        end
      end
      ACT_REM_HEAD: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          head_nxt  = head_inc;
          count_nxt = count_r - CW'(1);
        end
      end
      ACT_REM_TAIL: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - CW'(1);
        end
      end
      ACT_RD_HEAD: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ram_re  = 1'b1;
          rok_nxt = 1'b1;
        end
      end
      ACT_RD_TAIL: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          ram_re   = 1'b1;
          ram_addr = last_slot;
          rok_nxt  = 1'b1;
        end
      end
      ACT_RD_AT: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (CMPW'(pos_r) >= CMPW'(count_r)) begin
          status_nxt = ST_RANGE;
        end else begin
          ram_re   = 1'b1;
          ram_addr = at_slot;
          rok_nxt  = 1'b1;
        end
      end
      default: begin
        // unused code: no state change, status ok
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_data.action;
      elem_r <= in_data.element_in;
      pos_r  <= in_data.position;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      count_r  <= '0;
      status_r <= ST_OK;
      rok_r    <= 1'b0;
    end else if (cmd.exec) begin
      head_r   <= head_nxt;
      count_r  <= count_nxt;
      status_r <= status_nxt;
      rok_r    <= rok_nxt;
    end
  end

  dq_ram #(
    .WIDTH (ELEMENT_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we && cmd.exec),
    .re    (ram_re && cmd.exec),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_data.element_out = '0;
    if (rok_r) begin
      out_data.element_out[KEEP-1:0] = ram_rdata[KEEP-1:0];
    end
  end

  assign out_data.occupancy = OCC_W'(count_r);
  assign out_data.status    = status_r;

endmodule

/* hw/rtl/bounded_deque_with_indexed_read_unit.sv */
// Bounded deque unit: ring of CAPACITY element words with head pointer and count.
// A transaction accepted by the sequencer is captured, executed against the storage and
// then strobed on out_valid with its result. A new transaction is taken once the last
// has executed; the single RAM port makes one access per transaction, registered read data.
// Reset (synchronous, active low) clears head pointer, count and the sequencer; the
// storage is not cleared, since only live entries are ever read.
module bounded_deque_with_indexed_read_unit
  import dq_pkg::*;
#(
  parameter int CAPACITY     = 256,
  parameter int ELEMENT_BITS = 32
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  dq_in_t  in_data,
  output logic    out_valid,
  output dq_out_t out_data
);

  // Command bundle from sequencer to datapath
  dq_cmd_t cmd;

  // Sequencer: accept in idle or done, then execute, and present the result next.
  // busy only covers the execute cycle, so a new transaction may be taken while
  // the previous result is on the output.
  dq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Datapath: capture the transaction, compute the ring slot, access storage,
  // update head and count, and hold status and occupancy for the result.
  dq_dpath #(
    .CAPACITY     (CAPACITY),
    .ELEMENT_BITS (ELEMENT_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // Every result comes right after an execute cycle
  a_valid_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobe without a preceding execute cycle");

  // Execute is always followed in the next cycle by a result, not by another execute
  a_exec_then_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("execute cycle not followed by a result");

  // Errors never return element data
  a_error_zero_elem: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> (out_data.element_out == '0))
    else $error("nonzero element on error status");

endmodule

/* tb/bounded_deque_with_indexed_read_unit_tb.sv */
// Self-checking testbench for the bounded deque unit with indexed read.
// Depends on dq_pkg and bounded_deque_with_indexed_read_unit; drives random and
// directed actions, predicts every result and checks it field by field.
module bounded_deque_with_indexed_read_unit_tb;
  import dq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP        = 256;
  localparam int ITEMS      = 1350;
  localparam int SHOW_LIMIT = 10;
  // The one action code that the block ignores
  localparam logic [ACT_W-1:0] ACT_NOP = 3'd7;

  // One queued transaction plus a flag that holds it back until the unit drains
  typedef struct {
    dq_in_t txn;
    bit     settle;
  } deque_request_t;

  logic    clk;
  logic    rst_n;
  logic    start   = 1'b0;
  dq_in_t  in_data = '0;
  logic    busy;
  logic    out_valid;
  dq_out_t out_data;

  deque_request_t request_q[$];
  dq_out_t        expected_q[$];

  // Shadow of the deque, advanced once per accepted transaction
  logic [ELEM_W-1:0] ring_mem[CAP];
  logic [POS_W-1:0]  ring_head  = '0;
  logic [OCC_W-1:0]  ring_count = '0;

  // Occupancy as seen by the stimulus generator, used to shape well-formed runs
  int gen_occ = 0;

  logic drained = 1'b1;
  int   sent_count = 0;
  int   result_count = 0;
  int   fail_count = 0;
  int   full_seen = 0;
  int   empty_seen = 0;
  int   range_seen = 0;
  int   peak_occ = 0;

  bounded_deque_with_indexed_read_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hold reset low from time zero, then release it for good
  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Apply one action to the shadow deque and return the result it must produce
  function automatic dq_out_t apply_deque_action(dq_in_t t);
    dq_out_t r;
    r = '0;
    case (t.action)
      ACT_INS_HEAD: begin
        if (ring_count == CAP) begin
          r.status = ST_FULL;
        end else begin
          ring_head = ring_head - 1'b1;
          ring_mem[ring_head] = t.element_in;
          ring_count = ring_count + 1'b1;
        end
      end
      ACT_INS_TAIL: begin
        if (ring_count == CAP) begin
          r.status = ST_FULL;
        end else begin
          ring_mem[ring_head + ring_count[POS_W-1:0]] = t.element_in;
          ring_count = ring_count + 1'b1;
        end
      end
      ACT_REM_HEAD: begin
        if (ring_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          ring_head = ring_head + 1'b1;
          ring_count = ring_count - 1'b1;
        end
      end
      ACT_REM_TAIL: begin
        if (ring_count == 0) r.status = ST_EMPTY;
        else ring_count = ring_count - 1'b1;
      end
      ACT_RD_HEAD: begin
        if (ring_count == 0) r.status = ST_EMPTY;
        else r.element_out = ring_mem[ring_head];
      end
      ACT_RD_TAIL: begin
        if (ring_count == 0) r.status = ST_EMPTY;
        else r.element_out = ring_mem[ring_head + POS_W'(ring_count - 1'b1)];
      end
      ACT_RD_AT: begin
        if (ring_count == 0) r.status = ST_EMPTY;
        else if (OCC_W'(t.position) >= ring_count) r.status = ST_RANGE;
        else r.element_out = ring_mem[ring_head + t.position];
      end
      default: ;  // unused code: no state change, all-zero payload
    endcase
    r.occupancy = ring_count;
    return r;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= SHOW_LIMIT) $display("%0t: %s", $realtime, msg);
  endfunction

  // Queue one transaction and track the occupancy it leaves behind
  function automatic void push_request(logic [ACT_W-1:0] act, logic [ELEM_W-1:0] word,
                                       logic [POS_W-1:0] pos, bit settle);
    deque_request_t req;
    req.txn.action     = act;
    req.txn.element_in = word;
    req.txn.position   = pos;
    req.settle         = settle;
    request_q.push_back(req);
    if ((act == ACT_INS_HEAD || act == ACT_INS_TAIL) && gen_occ < CAP) gen_occ++;
    if ((act == ACT_REM_HEAD || act == ACT_REM_TAIL) && gen_occ > 0) gen_occ--;
  endfunction

  // Mostly full random words, with the all-zero, all-one and one-hot corners mixed in
  function automatic logic [ELEM_W-1:0] pick_word();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return '0;
    if (sel == 1) return '1;
    if (sel == 2) return ELEM_W'(1) << $urandom_range(ELEM_W - 1);
    return $urandom;
  endfunction

  // Mostly live positions, sometimes past the tail
  function automatic logic [POS_W-1:0] pick_position();
    if (gen_occ > 0 && $urandom_range(4) != 0) return POS_W'($urandom_range(gen_occ - 1));
    return POS_W'($urandom_range(255));
  endfunction

  function automatic void push_read(bit settle);
    case ($urandom_range(2))
      0: push_request(ACT_RD_HEAD, pick_word(), pick_position(), settle);
      1: push_request(ACT_RD_TAIL, pick_word(), pick_position(), settle);
      default: push_request(ACT_RD_AT, pick_word(), pick_position(), settle);
    endcase
  endfunction

  // Grow toward a target occupancy; at full, poke the full rejection and the last slot
  function automatic void fill_run(int target, bit settle);
    push_read(settle);
    while (gen_occ < target) begin
      if ($urandom_range(4) == 0) push_read(1'b0);
      else push_request($urandom_range(1) ? ACT_INS_HEAD : ACT_INS_TAIL,
                        pick_word(), pick_position(), 1'b0);
    end
    if (gen_occ == CAP) begin
      push_request(ACT_INS_HEAD, pick_word(), pick_position(), 1'b0);
      push_request(ACT_INS_TAIL, pick_word(), pick_position(), 1'b0);
      push_request(ACT_RD_AT, pick_word(), POS_W'(CAP - 1), 1'b0);
      push_request(ACT_RD_TAIL, pick_word(), pick_position(), 1'b0);
    end
  endfunction

  // Shrink toward a target occupancy; once empty, poke the empty rejections
  function automatic void drain_run(int target, bit settle);
    push_read(settle);
    while (gen_occ > target) begin
      if ($urandom_range(4) == 0) push_read(1'b0);
      else push_request($urandom_range(1) ? ACT_REM_HEAD : ACT_REM_TAIL,
                        pick_word(), pick_position(), 1'b0);
    end
    if (gen_occ == 0) begin
      push_request(ACT_REM_TAIL, pick_word(), pick_position(), 1'b0);
      push_request(ACT_RD_AT, pick_word(), POS_W'($urandom_range(255)), 1'b0);
      push_request(ACT_RD_HEAD, pick_word(), pick_position(), 1'b0);
    end
  endfunction

  // Driver: present the next queued transaction, hold it while busy, idle at random.
  // Transactions 500..749 go out with no random idling.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && busy) begin
      // hold the current transaction until the unit takes it
    end else if (request_q.size() == 0) begin
      start <= 1'b0;
    end else if (request_q[0].settle && (start || !drained)) begin
      start <= 1'b0;
    end else if (($urandom_range(99) < 24) && !(sent_count >= 500 && sent_count < 750)) begin
      start <= 1'b0;
    end else begin
      in_data <= request_q[0].txn;
      start   <= 1'b1;
      void'(request_q.pop_front());
      sent_count++;
    end
  end

  // Monitor: check the strobed result against the oldest prediction, then
  // predict the transaction accepted at this edge. Doing both here keeps the
  // expectation queue free of ordering races between processes.
  always @(posedge clk) begin
    dq_out_t want;
    if (rst_n) begin
      if (out_valid) begin
        result_count++;
        if (expected_q.size() == 0) begin
          note_failure($sformatf("result with nothing pending: elem %h occ %0d status %0d",
                                 out_data.element_out, out_data.occupancy, out_data.status));
        end else begin
          want = expected_q.pop_front();
          if (out_data.element_out !== want.element_out ||
              out_data.occupancy !== want.occupancy ||
              out_data.status !== want.status)
            note_failure($sformatf(
              "result %0d: expected elem %h occ %0d status %0d, got elem %h occ %0d status %0d",
              result_count, want.element_out, want.occupancy, want.status,
              out_data.element_out, out_data.occupancy, out_data.status));
        end
      end
      if (start && !busy) begin
        want = apply_deque_action(in_data);
        expected_q.push_back(want);
        if (want.status == ST_FULL) full_seen++;
        if (want.status == ST_EMPTY) empty_seen++;
        if (want.status == ST_RANGE) range_seen++;
        if (int'(want.occupancy) > peak_occ) peak_occ = int'(want.occupancy);
      end
      drained <= (expected_q.size() == 0);
    end
  end

  // Stimulus and end of run
  initial begin
    int wait_cycles;
    // Empty deque: every removal and read is rejected, including read at any position
    push_request(ACT_REM_HEAD, '0, '0, 1'b0);
    push_request(ACT_REM_TAIL, '1, '1, 1'b0);
    push_request(ACT_RD_HEAD, '0, '0, 1'b0);
    push_request(ACT_RD_TAIL, '0, '0, 1'b0);
    push_request(ACT_RD_AT, '0, 8'd0, 1'b0);
    push_request(ACT_RD_AT, '1, 8'd255, 1'b0);
    push_request(ACT_NOP, '1, '1, 1'b0);
    // Build a short list from both ends with corner words
    push_request(ACT_INS_TAIL, 32'h0000_0000, '0, 1'b0);
    push_request(ACT_INS_HEAD, 32'hFFFF_FFFF, '1, 1'b0);
    push_request(ACT_INS_TAIL, 32'hA5A5_A5A5, 8'h5A, 1'b0);
    push_request(ACT_INS_HEAD, 32'h5A5A_5A5A, 8'hA5, 1'b0);
    push_request(ACT_RD_HEAD, '0, '0, 1'b0);
    push_request(ACT_RD_TAIL, '0, '0, 1'b0);
    push_request(ACT_RD_AT, '0, 8'd0, 1'b0);
    push_request(ACT_RD_AT, '0, 8'd3, 1'b0);
    push_request(ACT_RD_AT, '0, 8'd4, 1'b0);
    push_request(ACT_RD_AT, '0, 8'd255, 1'b0);
    push_request(ACT_NOP, 32'h1234_5678, 8'd1, 1'b0);
    push_request(ACT_REM_HEAD, '0, '0, 1'b0);
    push_request(ACT_REM_TAIL, '0, '0, 1'b0);
    push_request(ACT_RD_HEAD, '0, '0, 1'b0);
    push_request(ACT_RD_TAIL, '0, '0, 1'b0);

    // Random part: one full fill and full drain first, then random phases.
    // Hold off the first random transaction until the directed ones are all back.
    fill_run(CAP, 1'b1);
    drain_run(0, 1'b0);
    while (request_q.size() < ITEMS) begin
      case ($urandom_range(9))
        0, 1, 2: fill_run($urandom_range(1) ? CAP : $urandom_range(CAP, gen_occ),
                          $urandom_range(3) == 0);
        3, 4: drain_run($urandom_range(1) ? 0 : $urandom_range(gen_occ), $urandom_range(3) == 0);
        default: begin
          push_request(ACT_REM_HEAD, pick_word(), pick_position(), $urandom_range(3) == 0);
          repeat (30) push_request(3'($urandom_range(7)), pick_word(), pick_position(), 1'b0);
        end
      endcase
    end

    // Wait on settled values: let the driver empty its queue and the results return
    do @(negedge clk); while (request_q.size() != 0 || start);
    wait_cycles = 0;
    while (!drained && wait_cycles < 100) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (8) @(negedge clk);
    if (expected_q.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_q.size()));

    $display("ran %0d transactions and checked %0d results; peak occupancy %0d",
             sent_count, result_count, peak_occ);
    $display("rejections seen: %0d full, %0d empty, %0d out of range; %0d failures",
             full_seen, empty_seen, range_seen, fail_count);
    if (fail_count == 0) begin
      $display("bounded_deque_with_indexed_read_unit_tb: done, clean");
    end else begin
      $display("bounded_deque_with_indexed_read_unit_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: stop a hung run well past the slowest correct one
  initial begin
    #2_000_000;
    $display("timeout waiting for the unit");
    $display("bounded_deque_with_indexed_read_unit_tb: done, errors");
    $finish;
  end

endmodule
